// ----- rtl/mbd_pkg.sv -----
// Shared types and constants of the mipmap box downsampler.
package mbd_pkg;

  localparam int CFG_W  = 11;  // configuration data width
  localparam int CH_W   = 8;   // bits per channel
  localparam int NCH    = 4;   // channels per pixel
  localparam int PS_W   = CH_W + 1;  // width of a horizontal pair sum
  localparam int CNT_W  = 3;   // width of the channel count register
  localparam int IDX_W  = 2;   // width of the register index

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH     = 2'd0,
    REG_SRC_HEIGHT    = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] chan3;
    logic [CH_W-1:0] chan2;
    logic [CH_W-1:0] chan1;
    logic [CH_W-1:0] chan0;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] out3;
    logic [CH_W-1:0] out2;
    logic [CH_W-1:0] out1;
    logic [CH_W-1:0] out0;
    logic            last_pixel;
  } mip_t;

  typedef logic [NCH-1:0][CH_W-1:0] chan_vec_t;
  typedef logic [NCH-1:0][PS_W-1:0] pair_sum_t;

endpackage

// ----- rtl/mbd_stream_if.sv -----
// Valid/ready stream channel carrying one payload per transaction.
interface mbd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/mbd_line_buf.sv -----
// Line memory of pair sums: one write port, one registered read port.
module mbd_line_buf #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 36
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the read word until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/mipmap_box_downsample.sv -----
// Top level of the 2x2 box-filter mipmap downsampler.
//
// Usage: source pixels of one mipmap level enter on src_pix in raster order,
// one pixel per transaction, channels chan0..chan3. Each pixel of the next
// smaller level leaves on mip_pix as floor(sum/4) of its 2x2 source block;
// channels at or above channel_count, clamped to 1..4, read zero; last_pixel
// marks the final pixel of the level. A dimension of one is used twice, not halved.
// Configuration (src_width, src_height, channel_count) is written through
// wr_en/wr_index/wr_data while the block is idle; any write to one of them
// restarts the level at column 0, row 0.
//
// Throughput: one source pixel per clock, sustained while mip_pix is taken.
// The output pixel passes through the pending stage, which waits for the
// line memory read, and then the output register. Even-row pair sums live
// in a line memory of MAX_WIDTH/2 words.
//
// Reset: counters, held pixel and registers return to their defaults
// (1024 x 1024, four channels); the line memory needs no clearing.
// Stall: when mip_pix is not taken, the output register and one pending
// pixel behind it hold, and src_pix.ready drops until the output drains.
module mipmap_box_downsample
  import mbd_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_index,
  input  logic [CFG_W-1:0]    wr_data,
  mbd_stream_if.sink          src_pix,
  mbd_stream_if.source        mip_pix
);

  localparam int LD = MAX_WIDTH / 2;                  // line memory depth
  localparam int AW = (LD > 1) ? $clog2(LD) : 1;      // line memory address
  localparam int XW = $clog2(MAX_WIDTH);              // column counter
  localparam int YW = $clog2(MAX_HEIGHT);             // row counter
  localparam int WW = $clog2(MAX_WIDTH + 1);          // width value
  localparam int HW = $clog2(MAX_HEIGHT + 1);         // height value
  localparam int PW = NCH * PS_W;                     // packed pair sums

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] src_width;
  logic [CFG_W-1:0] src_height;
  logic [CNT_W-1:0] channel_count;
  logic             cfg_hit;

  always_comb begin
    cfg_hit = 1'b0;
    if (wr_en) begin
      unique case (wr_index)
        REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_CHANNEL_COUNT: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= CFG_W'(1024);
      src_height    <= CFG_W'(1024);
      channel_count <= CNT_W'(4);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SRC_WIDTH:     src_width     <= wr_data;
        REG_SRC_HEIGHT:    src_height    <= wr_data;
        REG_CHANNEL_COUNT: channel_count <= wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero reads as one, oversize saturates.
  logic [WW-1:0] w_eff, ow;
  logic [HW-1:0] h_eff, oh;
  logic          w_one, h_one;
  logic [NCH-1:0] chan_en;

  always_comb begin
    if (src_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(src_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(src_width);
    end
    if (src_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(src_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(src_height);
    end
    w_one = (w_eff == WW'(1));
    h_one = (h_eff == HW'(1));
    ow    = w_one ? WW'(1) : (w_eff >> 1);
    oh    = h_one ? HW'(1) : (h_eff >> 1);
    // Channel k active when k < clamp(channel_count, 1, 4).
    for (int k = 0; k < NCH; k++) begin
      chan_en[k] = (k == 0) || (32'(channel_count) > k);
    end
  end

  // ---------------------------------------------------------------------
  // Input stage: position tracking and horizontal pair sums
  // ---------------------------------------------------------------------
  logic [XW-1:0] col_count;
  logic [YW-1:0] row_count;
  chan_vec_t     held_pixel;
  chan_vec_t     pix;
  pair_sum_t     ps;
  logic          accept;
  logic          pair_done;
  logic [XW-1:0] ox;
  logic [YW-1:0] oy;
  logic          active, line_wr, produce, last_hit;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;

  assign pix = {src_pix.data.chan3, src_pix.data.chan2,
                src_pix.data.chan1, src_pix.data.chan0};

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      if (w_one) begin
        ps[k] = {pix[k], 1'b0};
      end else begin
        ps[k] = PS_W'(held_pixel[k]) + PS_W'(pix[k]);
      end
    end
    pair_done = w_one || col_count[0];
    ox        = w_one ? '0 : (col_count >> 1);
    oy        = h_one ? '0 : (row_count >> 1);
    active    = pair_done && (WW'(ox) < ow) && (h_one || (HW'(oy) < oh));
    // Even rows of a level taller than one park their pair sums.
    line_wr   = active && !h_one && !row_count[0];
    produce   = active && !line_wr;
    last_hit  = (WW'(ox) == ow - WW'(1)) && (HW'(oy) == oh - HW'(1));
    col_inc   = WW'(col_count) + WW'(1);
    row_inc   = HW'(row_count) + HW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      held_pixel <= '0;
    end else if (cfg_hit) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (!w_one && !col_count[0]) begin
        held_pixel <= pix;
      end
      if (col_inc >= w_eff) begin
        col_count <= '0;
        row_count <= (row_inc >= h_eff) ? '0 : row_inc[YW-1:0];
      end else begin
        col_count <= col_inc[XW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Line memory: even rows write, odd rows read the sum above
  // ---------------------------------------------------------------------
  logic [AW-1:0] slot;
  logic          line_rd;
  logic [PW-1:0] above_word;

  assign slot    = AW'(ox);
  assign line_rd = accept && produce && !h_one;

  mbd_line_buf #(
    .DEPTH (LD),
    .AW    (AW),
    .DW    (PW)
  ) u_line (
    .clk     (clk),
    .wr_en   (accept && line_wr),
    .wr_addr (slot),
    .wr_data (PW'(ps)),
    .rd_en   (line_rd),
    .rd_addr (slot),
    .rd_data (above_word)
  );

  // ---------------------------------------------------------------------
  // Pending stage: waits for the registered memory word
  // ---------------------------------------------------------------------
  logic           s1_valid;
  pair_sum_t      s1_ps;
  logic           s1_h_one;
  logic           s1_last;
  logic [NCH-1:0] s1_chan_en;
  logic           s1_move;
  logic           out_valid;
  mip_t           out_data;

  assign s1_move = s1_valid && (!out_valid || mip_pix.ready);
  // Stall the source only when the pending pixel cannot move on.
  assign src_pix.ready = !(s1_valid && !s1_move);
  assign accept        = src_pix.valid && src_pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= produce;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      s1_ps      <= ps;
      s1_h_one   <= h_one;
      s1_last    <= last_hit;
      s1_chan_en <= chan_en;
    end
  end

  // Vertical sum and divide by four.
  pair_sum_t   above;
  chan_vec_t   avg;
  logic [PS_W:0] vsum [NCH];

  always_comb begin
    above = s1_h_one ? s1_ps : pair_sum_t'(above_word);
    for (int k = 0; k < NCH; k++) begin
      vsum[k] = (PS_W + 1)'(above[k]) + (PS_W + 1)'(s1_ps[k]);
      avg[k]  = s1_chan_en[k] ? vsum[k][PS_W:2] : '0;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (mip_pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data.out0       <= avg[0];
      out_data.out1       <= avg[1];
      out_data.out2       <= avg[2];
      out_data.out3       <= avg[3];
      out_data.last_pixel <= s1_last;
    end
  end

  assign mip_pix.valid = out_valid;
  assign mip_pix.data  = out_data;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (WW'(col_count) < w_eff) && (HW'(row_count) < h_eff))
    else $error("source position outside the level");

  a_reset_pos: assert property (@(posedge clk)
    rst |=> (col_count == '0) && (row_count == '0) && !s1_valid && !out_valid)
    else $error("reset left position or pipeline state");

  a_read_fills_stage: assert property (@(posedge clk) disable iff (rst)
    line_rd |=> s1_valid)
    else $error("line read without a pending pixel");

  a_stall_blocks_src: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !mip_pix.ready) |-> !src_pix.ready)
    else $error("source accepted while the pending pixel is stuck");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (col_count == '0) && (row_count == '0))
    else $error("register write did not restart the level");

endmodule

// ----- test/mipmap_box_downsample_check.sv -----
// Checker for the mipmap downsampler: predicts each output pixel and compares it.
`timescale 1ns / 100ps

module mipmap_box_downsample_check
  import mbd_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data,
  input  logic             src_valid,
  input  logic             src_ready,
  input  pixel_t           src_data,
  input  logic             mip_valid,
  input  logic             mip_ready,
  input  mip_t             mip_data,
  output int               due_count,
  output int               mismatches
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [CNT_W-1:0] chans_reg;
  pair_sum_t        pair_line [LINE_DEPTH];
  pixel_t           held;
  int unsigned      col;
  int unsigned      row;
  mip_t             mip_due [$];
  int               miss;

  // Fold one source pixel into the model; return 1 when it completes an output pixel.
  function automatic bit fold_pixel(input pixel_t p, output mip_t res);
    int unsigned w, h, nch, ow, oh, ox, oy, s;
    chan_vec_t   cur, prev;
    pair_sum_t   ps, above;
    chan_vec_t   avg;
    bit          paired;
    bit          made;
    w   = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h   = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
    nch = (chans_reg == 0) ? 1 : (chans_reg > NCH ? NCH : chans_reg);
    ow  = (w > 1) ? w / 2 : 1;
    oh  = (h > 1) ? h / 2 : 1;
    cur = p;
    ps  = '0;
    res = '0;
    paired = 1'b0;
    made   = 1'b0;
    if (w == 1) begin
      // single column pairs with itself
      for (int k = 0; k < NCH; k++) ps[k] = {cur[k], 1'b0};
      paired = 1'b1;
    end else if ((col % 2) == 0) begin
      held = p;
    end else begin
      prev = held;
      for (int k = 0; k < NCH; k++) ps[k] = PS_W'(prev[k]) + PS_W'(cur[k]);
      paired = 1'b1;
    end
    if (paired) begin
      ox = (w == 1) ? 0 : col / 2;
      oy = (h == 1) ? 0 : row / 2;
      if (ox < ow && oy < oh) begin
        if (h != 1 && (row % 2) == 0) begin
          pair_line[ox % LINE_DEPTH] = ps;
        end else begin
          // single row uses its own pair sums as the row above
          above = (h == 1) ? ps : pair_line[ox % LINE_DEPTH];
          for (int k = 0; k < NCH; k++) begin
            s = above[k] + ps[k];
            avg[k] = (k < nch) ? CH_W'(s >> 2) : '0;
          end
          res.out0 = avg[0];
          res.out1 = avg[1];
          res.out2 = avg[2];
          res.out3 = avg[3];
          res.last_pixel = (ox == ow - 1) && (oy == oh - 1);
          made = 1'b1;
        end
      end
    end
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
    return made;
  endfunction

  always @(posedge clk) begin
    mip_t want;
    mip_t next;
    if (rst) begin
      width_reg  = 11'd1024;
      height_reg = 11'd1024;
      chans_reg  = 3'd4;
      held = '0;
      col  = 0;
      row  = 0;
      miss = 0;
      mip_due.delete();
    end else begin
      if (wr_en) begin
        case (cfg_reg_e'(wr_index))
          REG_SRC_WIDTH: begin
            width_reg = wr_data;
            col = 0;
            row = 0;
          end
          REG_SRC_HEIGHT: begin
            height_reg = wr_data;
            col = 0;
            row = 0;
          end
          REG_CHANNEL_COUNT: begin
            chans_reg = wr_data[CNT_W-1:0];
            col = 0;
            row = 0;
          end
          default: ;
        endcase
      end
      // compare output first: a pixel accepted now cannot already have its result out
      if (mip_valid && mip_ready) begin
        if (mip_due.size() == 0) begin
          $display("%0t: unexpected output pixel %02h %02h %02h %02h last=%0b", $time,
                   mip_data.out0, mip_data.out1, mip_data.out2, mip_data.out3,
                   mip_data.last_pixel);
          miss++;
        end else begin
          want = mip_due.pop_front();
          if (mip_data.out0 !== want.out0 || mip_data.out1 !== want.out1 ||
              mip_data.out2 !== want.out2 || mip_data.out3 !== want.out3 ||
              mip_data.last_pixel !== want.last_pixel) begin
            $display("%0t: mismatch expected %02h %02h %02h %02h last=%0b, actual %02h %02h %02h %02h last=%0b",
                     $time, want.out0, want.out1, want.out2, want.out3, want.last_pixel,
                     mip_data.out0, mip_data.out1, mip_data.out2, mip_data.out3,
                     mip_data.last_pixel);
            miss++;
          end
        end
      end
      if (src_valid && src_ready) begin
        if (fold_pixel(src_data, next)) mip_due.push_back(next);
      end
    end
    due_count  <= mip_due.size();
    mismatches <= miss;
  end

endmodule

// ----- test/mipmap_box_downsample_test.sv -----
// Testbench top of the mipmap downsampler: stimulus, idling and the final verdict.
`timescale 1ns / 100ps

module mipmap_box_downsample_test;
  import mbd_pkg::*;

  // Longest stretch without any transaction before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 400;

  logic             clk = 1'b0;
  logic             rst;
  logic             wr_en;
  cfg_reg_e         wr_index;
  logic [CFG_W-1:0] wr_data;
  int               due_count;
  int               mismatches;
  int               quiet;
  bit               src_calm;

  mbd_stream_if #(.payload_t(pixel_t)) src_pix ();
  mbd_stream_if #(.payload_t(mip_t))   mip_pix ();

  mipmap_box_downsample uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .src_pix  (src_pix),
    .mip_pix  (mip_pix)
  );

  mipmap_box_downsample_check mip_check (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .src_valid  (src_pix.valid),
    .src_ready  (src_pix.ready),
    .src_data   (src_pix.data),
    .mip_valid  (mip_pix.valid),
    .mip_ready  (mip_pix.ready),
    .mip_data   (mip_pix.data),
    .due_count  (due_count),
    .mismatches (mismatches)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: count cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst || (src_pix.valid && src_pix.ready) || (mip_pix.valid && mip_pix.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Pick a random channel value, biased toward the extremes.
  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.chan0 = rand_chan();
    p.chan1 = rand_chan();
    p.chan2 = rand_chan();
    p.chan3 = rand_chan();
    return p;
  endfunction

  // Mostly small powers of two; now and then zero or an odd or uneven size.
  function automatic logic [CFG_W-1:0] pick_dim(input int max_log);
    if ($urandom_range(9, 0) == 0) return CFG_W'($urandom_range(12, 0));
    return CFG_W'(1 << $urandom_range(max_log, 0));
  endfunction

  // Write all three registers on back-to-back cycles; hold wr_en high throughout.
  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic [CFG_W-1:0] n);
    wr_en    <= 1'b1;
    wr_index <= REG_SRC_WIDTH;
    wr_data  <= w;
    @(posedge clk);
    wr_index <= REG_SRC_HEIGHT;
    wr_data  <= h;
    @(posedge clk);
    wr_index <= REG_CHANNEL_COUNT;
    wr_data  <= n;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // Offer one pixel after a random gap and return at the edge that takes it.
  // Valid stays high on return so a back-to-back pixel never toggles it.
  task automatic send_pixel(input pixel_t p);
    int gap;
    if ($urandom_range(31, 0) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(14, 0);
    if (gap > 0) begin
      src_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_pix.valid <= 1'b1;
    src_pix.data  <= p;
    @(posedge clk);
    while (!src_pix.ready) @(posedge clk);
  endtask

  // Hold off the sender until every predicted pixel is out, then let the
  // pipeline settle: a pixel that makes no output may still be in flight.
  task automatic drain();
    src_pix.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random level: configure, stream pixels, pause at random, drain at the end.
  task automatic run_level(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic [CFG_W-1:0] n, input int count);
    configure(w, h, n);
    repeat (count) begin
      send_pixel(rand_pixel());
      if ($urandom_range(63, 0) == 0) drain();
    end
    drain();
  endtask

  // Output side: stall a random number of cycles before each transaction.
  initial begin : result_sink
    int gap;
    bit calm;
    calm = 1'b0;
    mip_pix.ready = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(31, 0) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(14, 0);
      if (gap > 0) begin
        mip_pix.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      mip_pix.ready <= 1'b1;
      @(posedge clk);
      while (!mip_pix.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int               random_items;
    int               level;
    int               count;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] n;
    random_items  = 0;
    src_calm      = 1'b0;
    rst           = 1'b1;
    wr_en         = 1'b0;
    wr_index      = REG_SRC_WIDTH;
    wr_data       = '0;
    src_pix.valid = 1'b0;
    src_pix.data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // 4x2 level: one block of all-ones, one block that exercises rounding down.
    configure(11'd4, 11'd2, 11'd4);
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'h00, 8'h01, 8'h02, 8'h03});
    send_pixel({8'hFF, 8'h00, 8'h7F, 8'h80});
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'h03, 8'h02, 8'h01, 8'h00});
    send_pixel({8'h00, 8'hFF, 8'h80, 8'h7F});
    drain();

    // Width one, two channels: each pixel pairs with itself; run two levels.
    configure(11'd1, 11'd2, 11'd2);
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'h00, 8'h00, 8'h00, 8'h01});
    send_pixel({8'h80, 8'h7F, 8'h01, 8'hFE});
    send_pixel({8'hFF, 8'h00, 8'hFF, 8'h00});
    drain();

    // Height one, one channel: the pair sum stands in for both rows.
    configure(11'd2, 11'd1, 11'd1);
    send_pixel({8'h10, 8'h20, 8'h30, 8'hFF});
    send_pixel({8'h01, 8'h02, 8'h03, 8'hFE});
    drain();

    // One by one, channel count above four clamps to four.
    configure(11'd1, 11'd1, 11'd7);
    send_pixel({8'hAA, 8'h55, 8'hFF, 8'h01});
    drain();

    // Zero dimensions and zero channels read as one.
    configure(11'd0, 11'd0, 11'd0);
    send_pixel({8'h12, 8'h34, 8'h56, 8'h78});
    drain();

    // Odd 3x3 level: last column and last row make no output.
    configure(11'd3, 11'd3, 11'd3);
    repeat (9) send_pixel(rand_pixel());
    drain();

    // Random levels, mostly whole, sometimes cut short or running into the next.
    while (random_items < RANDOM_ITEMS) begin
      w = pick_dim(5);
      h = pick_dim(4);
      n[CNT_W-1:0] = ($urandom_range(7, 0) == 0) ? CNT_W'($urandom_range(7, 0))
                                                 : CNT_W'($urandom_range(4, 1));
      n[CFG_W-1:CNT_W] = ($urandom_range(3, 0) == 0) ? (CFG_W - CNT_W)'($urandom_range(255, 0))
                                                     : '0;
      level = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      case ($urandom_range(5, 0))
        0: count = $urandom_range(level, 1);
        1: count = level + $urandom_range(level, 1);
        default: count = level;
      endcase
      run_level(w, h, n, count);
      random_items += count;
    end

    // Extremes, cut short: saturated width in one row, saturated height in one column.
    run_level(11'd2047, 11'd1, 11'd5, 256);
    run_level(11'd1, 11'd2047, 11'd3, 128);

    // drain() already waited for the last output and the pipeline latency.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- mipmap_box_downsample.f -----
rtl/mbd_pkg.sv
rtl/mbd_stream_if.sv
rtl/mbd_line_buf.sv
rtl/mipmap_box_downsample.sv
test/mipmap_box_downsample_check.sv
test/mipmap_box_downsample_test.sv
